// ----- hw/rtl/itf_pkg.sv -----
// Shared types, constants and helper functions of the integer text formatter.
`timescale 1ns / 1ps

package itf_pkg;

    localparam int MAX_DIGITS  = 32;
    localparam int MAX_FIELD   = 48;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int LEN_W       = $clog2(MAX_DIGITS + MAX_FIELD + 2);
    localparam int RADIX_MIN   = 2;
    localparam int RADIX_MAX   = 36;

    // command queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] SGN_NONE  = 2'd0;
    localparam logic [1:0] SGN_MINUS = 2'd1;
    localparam logic [1:0] SGN_PLUS  = 2'd2;
    localparam logic [1:0] SGN_SPACE = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    typedef struct packed {
        logic [31:0] mag;
        logic [5:0]  radix;
        logic [5:0]  width;
        logic [5:0]  prec;
        logic [1:0]  sign;
        logic        left_j;
        logic        zpad;
        logic        upper;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // floor(2^32 / radix), used for the quotient estimate
    function automatic logic [31:0] radix_recip(input logic [5:0] radix);
        logic [31:0] r;
        unique case (radix)
            6'd2:  r = 32'h8000_0000;
            6'd3:  r = 32'(64'h1_0000_0000 / 3);
            6'd4:  r = 32'(64'h1_0000_0000 / 4);
            6'd5:  r = 32'(64'h1_0000_0000 / 5);
            6'd6:  r = 32'(64'h1_0000_0000 / 6);
            6'd7:  r = 32'(64'h1_0000_0000 / 7);
            6'd8:  r = 32'(64'h1_0000_0000 / 8);
            6'd9:  r = 32'(64'h1_0000_0000 / 9);
            6'd10: r = 32'(64'h1_0000_0000 / 10);
            6'd11: r = 32'(64'h1_0000_0000 / 11);
            6'd12: r = 32'(64'h1_0000_0000 / 12);
            6'd13: r = 32'(64'h1_0000_0000 / 13);
            6'd14: r = 32'(64'h1_0000_0000 / 14);
            6'd15: r = 32'(64'h1_0000_0000 / 15);
            6'd16: r = 32'(64'h1_0000_0000 / 16);
            6'd17: r = 32'(64'h1_0000_0000 / 17);
            6'd18: r = 32'(64'h1_0000_0000 / 18);
            6'd19: r = 32'(64'h1_0000_0000 / 19);
            6'd20: r = 32'(64'h1_0000_0000 / 20);
            6'd21: r = 32'(64'h1_0000_0000 / 21);
            6'd22: r = 32'(64'h1_0000_0000 / 22);
            6'd23: r = 32'(64'h1_0000_0000 / 23);
            6'd24: r = 32'(64'h1_0000_0000 / 24);
            6'd25: r = 32'(64'h1_0000_0000 / 25);
            6'd26: r = 32'(64'h1_0000_0000 / 26);
            6'd27: r = 32'(64'h1_0000_0000 / 27);
            6'd28: r = 32'(64'h1_0000_0000 / 28);
            6'd29: r = 32'(64'h1_0000_0000 / 29);
            6'd30: r = 32'(64'h1_0000_0000 / 30);
            6'd31: r = 32'(64'h1_0000_0000 / 31);
            6'd32: r = 32'(64'h1_0000_0000 / 32);
            6'd33: r = 32'(64'h1_0000_0000 / 33);
            6'd34: r = 32'(64'h1_0000_0000 / 34);
            6'd35: r = 32'(64'h1_0000_0000 / 35);
            6'd36: r = 32'(64'h1_0000_0000 / 36);
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CH_ZERO + {2'b00, d};
        end else begin
            c = (upper ? CH_UA : CH_LA) + {2'b00, d} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] sign_char(input logic [1:0] sign);
        logic [7:0] c;
        unique case (sign)
            SGN_MINUS: c = CH_MINUS;
            SGN_PLUS:  c = CH_PLUS;
            SGN_SPACE: c = CH_SPACE;
            default:   c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/integer_text_formatter_core.sv -----
// Top level of the integer text formatter: input stage, command queue, conversion engine.
//
//  channel   dir  data bits               side band
//  s_axis    in   56 (value .. upper_case) tuser = is_signed
//  m_axis    out  8  (text_char)           tlast = last_char
//
// Each value is loaded, then each digit takes a 32x32 reciprocal
// multiply followed by a correcting subtract, then a setup step, then
// one character per cycle while the output is not stalled.
// Synchronous active-low reset empties the queue and idles the engine.
// The input stalls only when the two-entry queue is full; the output
// register holds a character until it is taken.
`timescale 1ns / 1ps

module integer_text_formatter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // value[31:0], radix[37:32], total_width[43:38],
                                       // min_digits[49:44], left_justify[50], zero_pad[51],
                                       // force_plus[52], space_sign[53], upper_case[54]
    input  logic        s_axis_tuser,  // is_signed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // text_char
    output logic        m_axis_tlast   // last_char
);
    import itf_pkg::*;

    t_cmd    w_push_cmd;
    t_cmd    w_pop_cmd;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;
    logic    w_busy;

    itf_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    itf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_stat  (w_q_stat)
    );

    itf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_pop_cmd),
        .i_cmd_valid   (!w_q_stat.empty),
        .o_pop         (w_pop),
        .o_busy        (w_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    a_pop_starts_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> w_busy)
        else $error("engine did not start after pop");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_busy)
        else $error("pop while engine busy");
`endif

endmodule

// ----- hw/rtl/itf_front.sv -----
// Input stage: unpacks a transfer, checks the radix, saturates limits, splits sign and magnitude.
`timescale 1ns / 1ps

module itf_front (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // value, radix, total_width, min_digits,
                                                // left_justify, zero_pad, force_plus,
                                                // space_sign, upper_case, zero fill
    input  logic                 s_axis_tuser,  // is_signed
    input  itf_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output itf_pkg::t_cmd        o_cmd
);
    import itf_pkg::*;

    logic [31:0] w_value;
    logic [5:0]  w_radix;
    logic [5:0]  w_width;
    logic [5:0]  w_prec;
    logic        w_neg;
    logic        w_radix_ok;

    assign w_value = s_axis_tdata[31:0];
    assign w_radix = s_axis_tdata[37:32];
    assign w_width = s_axis_tdata[43:38];
    assign w_prec  = s_axis_tdata[49:44];
    assign w_neg   = s_axis_tuser & w_value[31];

    assign w_radix_ok = (w_radix >= 6'(RADIX_MIN)) && (w_radix <= 6'(RADIX_MAX));

    assign s_axis_tready = !i_q_stat.full;
    // bad radix: transfer is taken and dropped
    assign o_push = s_axis_tvalid && !i_q_stat.full && w_radix_ok;

    always_comb begin
        o_cmd.mag    = w_neg ? (32'd0 - w_value) : w_value;
        o_cmd.radix  = w_radix;
        o_cmd.width  = (w_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : w_width;
        o_cmd.prec   = (w_prec > 6'(MAX_FIELD - 1)) ? 6'(MAX_FIELD - 1) : w_prec;
        o_cmd.left_j = s_axis_tdata[50];
        o_cmd.zpad   = s_axis_tdata[51];
        o_cmd.upper  = s_axis_tdata[54];
        priority if (w_neg) begin
            o_cmd.sign = SGN_MINUS;
        end else if (s_axis_tuser && s_axis_tdata[52]) begin
            o_cmd.sign = SGN_PLUS;
        end else if (s_axis_tuser && s_axis_tdata[53]) begin
            o_cmd.sign = SGN_SPACE;
        end else begin
            o_cmd.sign = SGN_NONE;
        end
    end

endmodule

// ----- hw/rtl/itf_queue.sv -----
// Short command queue between the input stage and the conversion engine.
`timescale 1ns / 1ps

module itf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  itf_pkg::t_cmd        i_cmd,
    input  logic                 i_pop,
    output itf_pkg::t_cmd        o_cmd,
    output itf_pkg::t_q_stat     o_stat
);
    import itf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hw/rtl/itf_back.sv -----
// Conversion engine: digit extraction by reciprocal multiply, then character emission.
`timescale 1ns / 1ps

module itf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itf_pkg::t_cmd        i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_pop,
    output logic                 o_busy,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // text_char
    output logic                 m_axis_tlast   // last_char
);
    import itf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [31:0]          r_q, n_q;
    logic [31:0]          r_recip, n_recip;
    logic [31:0]          r_qest, n_qest;
    logic [5:0]           r_radix, n_radix;
    logic [5:0]           r_width, n_width;
    logic [5:0]           r_prec, n_prec;
    logic [1:0]           r_sign, n_sign;
    logic                 r_left_j, n_left_j;
    logic                 r_zpad, n_zpad;
    logic                 r_upper, n_upper;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_dleft, n_dleft;
    logic [LEN_W-1:0]     r_lead, n_lead;
    logic [LEN_W-1:0]     r_zero, n_zero;
    logic [LEN_W-1:0]     r_left, n_left;
    logic [DIG_IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic [5:0]           r_rd_data;
    logic [5:0]           r_dig_mem [MAX_DIGITS];
    logic                 r_mvalid, n_mvalid;
    logic [7:0]           r_mdata, n_mdata;
    logic                 r_mlast, n_mlast;

    logic [63:0]          w_prod;
    logic [31:0]          w_qb;
    logic [31:0]          w_rem;
    logic [31:0]          w_rem_c;
    logic                 w_corr;
    logic [5:0]           w_digit;
    logic [31:0]          w_q_new;
    logic [LEN_W-1:0]     w_body;
    logic [LEN_W-1:0]     w_used;
    logic [LEN_W-1:0]     w_pad;
    logic                 w_emit;
    logic [7:0]           w_char;

    assign w_prod  = {32'd0, r_q} * {32'd0, r_recip};
    assign w_qb    = r_qest * {26'd0, r_radix};
    assign w_rem   = r_q - w_qb;
    assign w_rem_c = w_rem - {26'd0, r_radix};
    // estimate is at most one low
    assign w_corr  = (w_rem >= {26'd0, r_radix});
    assign w_digit = w_corr ? w_rem_c[5:0] : w_rem[5:0];
    assign w_q_new = r_qest + {31'd0, w_corr};

    assign w_body = (LEN_W'(r_cnt) > LEN_W'(r_prec)) ? LEN_W'(r_cnt) : LEN_W'(r_prec);
    assign w_used = w_body + LEN_W'(r_sign != SGN_NONE);
    assign w_pad  = (LEN_W'(r_width) > w_used) ? (LEN_W'(r_width) - w_used) : '0;

    assign w_emit = (r_state == S_EMIT) && (!r_mvalid || m_axis_tready);

    assign o_pop         = (r_state == S_IDLE) && i_cmd_valid;
    assign o_busy        = (r_state != S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    always_comb begin
        n_state   = r_state;
        n_q       = r_q;
        n_recip   = r_recip;
        n_qest    = r_qest;
        n_radix   = r_radix;
        n_width   = r_width;
        n_prec    = r_prec;
        n_sign    = r_sign;
        n_left_j  = r_left_j;
        n_zpad    = r_zpad;
        n_upper   = r_upper;
        n_cnt     = r_cnt;
        n_dleft   = r_dleft;
        n_lead    = r_lead;
        n_zero    = r_zero;
        n_left    = r_left;
        n_rd_addr = r_rd_addr;
        n_mvalid  = r_mvalid;
        n_mdata   = r_mdata;
        n_mlast   = r_mlast;
        w_char    = CH_SPACE;

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_q      = i_cmd.mag;
                    n_recip  = radix_recip(i_cmd.radix);
                    n_radix  = i_cmd.radix;
                    n_width  = i_cmd.width;
                    n_prec   = i_cmd.prec;
                    n_sign   = i_cmd.sign;
                    n_left_j = i_cmd.left_j;
                    n_zpad   = i_cmd.zpad;
                    n_upper  = i_cmd.upper;
                    n_cnt    = '0;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_qest  = w_prod[63:32];
                n_state = S_DIV;
            end
            S_DIV: begin
                n_q   = w_q_new;
                n_cnt = r_cnt + 1'b1;
                if ((w_q_new == 32'd0) || (r_cnt == CNT_W'(MAX_DIGITS - 1))) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SETUP: begin
                n_rd_addr = DIG_IDX_W'(r_cnt - 1'b1);
                n_dleft   = r_cnt;
                n_lead    = (!r_left_j && !r_zpad) ? w_pad : '0;
                n_zero    = ((!r_left_j && r_zpad) ? w_pad : '0) + w_body - LEN_W'(r_cnt);
                n_left    = w_used + w_pad;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    priority if (r_lead != '0) begin
                        w_char = CH_SPACE;
                        n_lead = r_lead - 1'b1;
                    end else if (r_sign != SGN_NONE) begin
                        w_char = sign_char(r_sign);
                        n_sign = SGN_NONE;
                    end else if (r_zero != '0) begin
                        w_char = CH_ZERO;
                        n_zero = r_zero - 1'b1;
                    end else if (r_dleft != '0) begin
                        w_char    = digit_char(r_rd_data, r_upper);
                        n_dleft   = r_dleft - 1'b1;
                        n_rd_addr = r_rd_addr - 1'b1;
                    end else begin
                        w_char = CH_SPACE;
                    end
                    n_mvalid = 1'b1;
                    n_mdata  = w_char;
                    n_mlast  = (r_left == LEN_W'(1));
                    n_left   = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_recip   <= n_recip;
        r_qest    <= n_qest;
        r_radix   <= n_radix;
        r_width   <= n_width;
        r_prec    <= n_prec;
        r_sign    <= n_sign;
        r_left_j  <= n_left_j;
        r_zpad    <= n_zpad;
        r_upper   <= n_upper;
        r_cnt     <= n_cnt;
        r_dleft   <= n_dleft;
        r_lead    <= n_lead;
        r_zero    <= n_zero;
        r_left    <= n_left;
        r_rd_addr <= n_rd_addr;
        r_mdata   <= n_mdata;
        r_mlast   <= n_mlast;
    end

    // digit store, least significant digit first
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            r_dig_mem[r_cnt[DIG_IDX_W-1:0]] <= w_digit;
        end
        r_rd_data <= r_dig_mem[n_rd_addr];
    end

endmodule
